>>> hw/rtl/ffsa_pkg.sv
// Shared constants, codes and controller/datapath interface types of the segment allocator.
`timescale 1ns / 1ps
package ffsa_pkg;

  localparam int unsigned ArenaBytesDef  = 16384;
  localparam int unsigned HeaderBytesDef = 32;
  localparam int unsigned MaxSegmentsDef = 64;

  localparam int unsigned FieldW = 15;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_START,
    OP_RD_IDX,
    OP_RD_NEXT,
    OP_STEP,
    OP_WR_USED,
    OP_SPLIT_PREP,
    OP_WR_REM,
    OP_SH_RD,
    OP_SH_WR,
    OP_WR_FREE,
    OP_C_INIT,
    OP_LOAD_CUR,
    OP_MERGE,
    OP_ADV,
    OP_CNT_DEC
  } ffsa_op_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK_ADDR,
    RES_OK_ZERO,
    RES_NOMEM,
    RES_INVALID
  } ffsa_res_e;

  typedef struct packed {
    ffsa_op_e  op;
    ffsa_res_e res;
  } ffsa_cmd_t;

  typedef struct packed {
    logic mode_free;
    logic fit;
    logic exact;
    logic split_ok;
    logic full;
    logic last;
    logic hit;
    logic both_free;
    logic sh_done;
  } ffsa_stat_t;

endpackage

>>> hw/rtl/ffsa_datapath.sv
// Datapath of the segment allocator: segment table memory, walk registers and result register.
`timescale 1ns / 1ps
module ffsa_datapath #(
  parameter int unsigned ARENA_BYTES  = ffsa_pkg::ArenaBytesDef,
  parameter int unsigned HEADER_BYTES = ffsa_pkg::HeaderBytesDef,
  parameter int unsigned MAX_SEGMENTS = ffsa_pkg::MaxSegmentsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ffsa_pkg::ffsa_cmd_t            cmd_i,
  output ffsa_pkg::ffsa_stat_t           stat_o,
  input  logic                           mode_i,
  input  logic [ffsa_pkg::FieldW-1:0]    request_bytes_i,
  input  logic [ffsa_pkg::FieldW-1:0]    free_address_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [ffsa_pkg::FieldW-1:0]    address_o
);
  import ffsa_pkg::*;

  localparam int unsigned SW   = $clog2(ARENA_BYTES + 1);
  localparam int unsigned IW   = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW   = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned CMPW = ((SW > FieldW) ? SW : FieldW) + 2;
  localparam logic [CMPW-1:0] HdrX    = CMPW'(HEADER_BYTES);
  localparam logic [SW-1:0]   HdrS    = SW'(HEADER_BYTES);
  localparam logic [SW-1:0]   InitSz  = SW'(ARENA_BYTES - HEADER_BYTES);

  logic [SW:0]        mem_q [MAX_SEGMENTS];
  logic [SW:0]        rdata_q;
  logic               mode_q;
  logic [FieldW-1:0]  req_q, where_q;
  logic [IW-1:0]      idx_q;
  logic [CW-1:0]      k_q, count_q;
  logic               dir_ins_q;
  logic [SW-1:0]      offset_q, rem_q, cur_size_q;
  logic               cur_used_q;

  logic [SW-1:0]      rsize;
  logic               rused;
  logic [CMPW-1:0]    size_x, req_x, off_hdr;
  logic [CW-1:0]      idx_p1;
  logic [IW-1:0]      rd_addr, wr_addr;
  logic               re, we;
  logic [SW:0]        wdata;
  logic [SW-1:0]      merged;

  assign rsize   = rdata_q[SW-1:0];
  assign rused   = rdata_q[SW];
  assign size_x  = CMPW'(rsize);
  assign req_x   = CMPW'(req_q);
  assign off_hdr = CMPW'(offset_q) + HdrX;
  assign idx_p1  = CW'(idx_q) + CW'(1);
  assign merged  = cur_size_q + rsize + HdrS;

  always_comb begin
    stat_o.mode_free = mode_q;
    stat_o.fit       = !rused && (size_x >= req_x);
    stat_o.exact     = (size_x == req_x);
    stat_o.split_ok  = size_x > (req_x + HdrX);
    stat_o.full      = count_q >= CW'(MAX_SEGMENTS);
    stat_o.last      = idx_p1 >= count_q;
    stat_o.hit       = off_hdr == CMPW'(where_q);
    stat_o.both_free = !cur_used_q && !rused;
    stat_o.sh_done   = dir_ins_q ? (k_q <= idx_p1) : ((k_q + CW'(1)) >= count_q);
  end

  // Memory port steering.
  always_comb begin
    re      = 1'b0;
    we      = 1'b0;
    rd_addr = idx_q;
    wr_addr = idx_q;
    wdata   = rdata_q;
    unique case (cmd_i.op)
      OP_INIT: begin
        we      = 1'b1;
        wr_addr = '0;
        wdata   = {1'b0, InitSz};
      end
      OP_RD_IDX:  re = 1'b1;
      OP_RD_NEXT: begin
        re      = 1'b1;
        rd_addr = idx_p1[IW-1:0];
      end
      OP_SH_RD: begin
        re      = 1'b1;
        rd_addr = dir_ins_q ? IW'(k_q - CW'(1)) : IW'(k_q + CW'(1));
      end
      OP_SH_WR: begin
        we      = 1'b1;
        wr_addr = k_q[IW-1:0];
        wdata   = rdata_q;
      end
      OP_WR_USED: begin
        we    = 1'b1;
        wdata = {1'b1, SW'(req_q)};
      end
      OP_WR_REM: begin
        we      = 1'b1;
        wr_addr = idx_p1[IW-1:0];
        wdata   = {1'b0, rem_q};
      end
      OP_WR_FREE: begin
        we    = 1'b1;
        wdata = {1'b0, rsize};
      end
      OP_MERGE: begin
        we    = 1'b1;
        wdata = {1'b0, merged};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Walk registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        mode_q   <= mode_i;
        req_q    <= request_bytes_i;
        where_q  <= free_address_i;
        idx_q    <= '0;
        offset_q <= '0;
      end
      OP_STEP: begin
        idx_q    <= idx_p1[IW-1:0];
        offset_q <= offset_q + HdrS + rsize;
      end
      OP_SPLIT_PREP: begin
        rem_q     <= SW'(size_x - req_x - HdrX);
        k_q       <= count_q;
        dir_ins_q <= 1'b1;
      end
      OP_SH_WR: k_q <= dir_ins_q ? (k_q - CW'(1)) : (k_q + CW'(1));
      OP_C_INIT: idx_q <= '0;
      OP_LOAD_CUR: begin
        cur_size_q <= rsize;
        cur_used_q <= rused;
      end
      OP_MERGE: begin
        cur_size_q <= merged;
        k_q        <= idx_p1;
        dir_ins_q  <= 1'b0;
      end
      OP_ADV: begin
        cur_size_q <= rsize;
        cur_used_q <= rused;
        idx_q      <= idx_p1[IW-1:0];
      end
      default: ;
    endcase
  end

  // Segment count and result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= CW'(1);
      done_o    <= 1'b0;
      status_o  <= ST_OK;
      address_o <= '0;
    end else begin
      if (cmd_i.op == OP_INIT) begin
        count_q <= CW'(1);
      end else if (cmd_i.op == OP_WR_REM) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.op == OP_CNT_DEC) begin
        count_q <= count_q - CW'(1);
      end
      done_o    <= cmd_i.res != RES_NONE;
      status_o  <= ST_OK;
      address_o <= '0;
      case (cmd_i.res)
        RES_OK_ADDR: address_o <= off_hdr[FieldW-1:0];
        RES_NOMEM:   status_o  <= ST_NOMEM;
        RES_INVALID: status_o  <= ST_INVALID;
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/ffsa_ctrl.sv
// Controller state machine of the segment allocator.
`timescale 1ns / 1ps
module ffsa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  ffsa_pkg::ffsa_stat_t  stat_i,
  output ffsa_pkg::ffsa_cmd_t   cmd_o
);
  import ffsa_pkg::*;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_ARD  = 4'd2;
  localparam logic [3:0] S_ACHK = 4'd3;
  localparam logic [3:0] S_SRD  = 4'd4;
  localparam logic [3:0] S_SWR  = 4'd5;
  localparam logic [3:0] S_WU   = 4'd6;
  localparam logic [3:0] S_WREM = 4'd7;
  localparam logic [3:0] S_C0   = 4'd8;
  localparam logic [3:0] S_CRD  = 4'd9;
  localparam logic [3:0] S_CCUR = 4'd10;
  localparam logic [3:0] S_CNXT = 4'd11;
  localparam logic [3:0] S_CCHK = 4'd12;
  localparam logic [3:0] S_RRD  = 4'd13;
  localparam logic [3:0] S_RWR  = 4'd14;

  logic [3:0] state_q, state_d;

  assign busy_o = state_q != S_IDLE;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    cmd_o.res = RES_NONE;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op = OP_INIT;
        state_d  = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_START;
          state_d  = S_ARD;
        end
      end
      S_ARD: begin
        cmd_o.op = OP_RD_IDX;
        state_d  = S_ACHK;
      end
      S_ACHK: begin
        if (!stat_i.mode_free && stat_i.fit) begin
          if (stat_i.exact) begin
            cmd_o.op  = OP_WR_USED;
            cmd_o.res = RES_OK_ADDR;
            state_d   = S_IDLE;
          end else if (stat_i.split_ok && !stat_i.full) begin
            cmd_o.op = OP_SPLIT_PREP;
            state_d  = S_SRD;
          end else begin
            cmd_o.res = RES_NOMEM;
            state_d   = S_IDLE;
          end
        end else if (stat_i.mode_free && stat_i.hit) begin
          cmd_o.op = OP_WR_FREE;
          state_d  = S_C0;
        end else if (stat_i.last) begin
          cmd_o.res = stat_i.mode_free ? RES_INVALID : RES_NOMEM;
          state_d   = S_IDLE;
        end else begin
          cmd_o.op = OP_STEP;
          state_d  = S_ARD;
        end
      end
      S_SRD: begin
        if (stat_i.sh_done) begin
          state_d = S_WU;
        end else begin
          cmd_o.op = OP_SH_RD;
          state_d  = S_SWR;
        end
      end
      S_SWR: begin
        cmd_o.op = OP_SH_WR;
        state_d  = S_SRD;
      end
      S_WU: begin
        cmd_o.op = OP_WR_USED;
        state_d  = S_WREM;
      end
      S_WREM: begin
        cmd_o.op  = OP_WR_REM;
        cmd_o.res = RES_OK_ADDR;
        state_d   = S_IDLE;
      end
      S_C0: begin
        cmd_o.op = OP_C_INIT;
        state_d  = S_CRD;
      end
      S_CRD: begin
        cmd_o.op = OP_RD_IDX;
        state_d  = S_CCUR;
      end
      S_CCUR: begin
        cmd_o.op = OP_LOAD_CUR;
        state_d  = S_CNXT;
      end
      S_CNXT: begin
        if (stat_i.last) begin
          cmd_o.res = RES_OK_ZERO;
          state_d   = S_IDLE;
        end else begin
          cmd_o.op = OP_RD_NEXT;
          state_d  = S_CCHK;
        end
      end
      S_CCHK: begin
        if (stat_i.both_free) begin
          cmd_o.op = OP_MERGE;
          state_d  = S_RRD;
        end else begin
          cmd_o.op = OP_ADV;
          state_d  = S_CNXT;
        end
      end
      S_RRD: begin
        if (stat_i.sh_done) begin
          cmd_o.op = OP_CNT_DEC;
          state_d  = S_CNXT;
        end else begin
          cmd_o.op = OP_SH_RD;
          state_d  = S_RWR;
        end
      end
      S_RWR: begin
        cmd_o.op = OP_SH_WR;
        state_d  = S_RRD;
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/first_fit_segment_allocator.sv
// Top level of the first-fit segment allocator with coalescing.
`timescale 1ns / 1ps
// Usage:
// A request beat is taken at a rising edge where start_i is high and busy_o is
// low. mode_i selects an allocate (0, size in request_bytes_i) or a free (1,
// payload offset in free_address_i). Each request yields exactly one result
// beat: done_o is high for one cycle with status_o and address_o valid.
// status_o is ok, no memory, or invalid address; address_o is the payload
// offset on a successful allocate and zero otherwise.
// Sequencing: the controller walks the segment table through a single read
// port of the table memory, with a read state and a check state per entry
// visited. A split shifts each entry above the split up by one, with a read
// and a write state per entry shifted; a free runs a merge pass with a read
// and a check state per entry, plus a read and a write state per entry
// shifted down on each merge. One request runs at a time; the next one can be
// accepted at the same edge that accepts the result beat.
// After reset the block writes the initial free segment in its init state,
// with busy_o high. The receiver cannot stall: result beats are not held.
module first_fit_segment_allocator #(
  parameter int unsigned ARENA_BYTES  = ffsa_pkg::ArenaBytesDef,
  parameter int unsigned HEADER_BYTES = ffsa_pkg::HeaderBytesDef,
  parameter int unsigned MAX_SEGMENTS = ffsa_pkg::MaxSegmentsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        mode_i,
  input  logic [ffsa_pkg::FieldW-1:0] request_bytes_i,
  input  logic [ffsa_pkg::FieldW-1:0] free_address_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [ffsa_pkg::FieldW-1:0] address_o
);
  import ffsa_pkg::*;

  ffsa_cmd_t  cmd;
  ffsa_stat_t stat;

  // The controller sequences the walk; the datapath owns the table.
  ffsa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  ffsa_datapath #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .mode_i          (mode_i),
    .request_bytes_i (request_bytes_i),
    .free_address_i  (free_address_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .address_o       (address_o)
  );

  // A result beat only ever closes a request that was in progress.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result beat without request");

  // An accepted request keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted request not busy");

  // Failed requests never report an address.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (address_o == '0))
    else $error("failed request carries an address");

  // The status code stays within the defined codes.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_NOMEM || status_o == ST_INVALID))
    else $error("undefined status code");

endmodule
